[rtl/core/mwcg_pkg.sv]
`default_nettype none

package mwcg_pkg;

    // field widths
    localparam int VEL_W   = 24;
    localparam int AGE_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CSUM_W  = 15;
    localparam int IDX_W   = 3;

    // datapath widths
    localparam int OPB_W   = 17;             // coefficient operand, signed
    localparam int PROD_W  = VEL_W + OPB_W;  // multiplier product
    localparam int SUM_W   = 44;             // cx, cy, cz and wheel sums, 26 frac bits
    localparam int CUT     = 22;             // 34 -> 12 fraction bits
    localparam int ACC_W   = 62;

    // microcode
    localparam int                STEP_W   = 5;
    localparam logic [STEP_W-1:0] FIN_STEP = STEP_W'(20);

    typedef enum logic [IDX_W-1:0] {
        REG_REF_TIMEOUT,
        REG_CMD_TIMEOUT,
        REG_COS_OFFSET,
        REG_SIN_OFFSET,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_CENTER_SUM,
        REG_INV_RADIUS
    } cfg_idx_t;

    typedef struct packed {
        logic        [AGE_W-1:0]  ref_limit;
        logic        [AGE_W-1:0]  cmd_limit;
        logic signed [CFG_W-1:0]  cos_offset_angle;
        logic signed [CFG_W-1:0]  sin_offset_angle;
        logic signed [CFG_W-1:0]  offset_x;
        logic signed [CFG_W-1:0]  offset_y;
        logic        [CSUM_W-1:0] center_sum;
        logic        [CFG_W-1:0]  inv_radius;
    } cfg_t;

    typedef enum logic [2:0] {A_VX, A_VY, A_WZ, A_SHI, A_SLO} a_sel_t;
    typedef enum logic [2:0] {B_COS, B_SIN, B_OFFX, B_OFFY, B_CSUM, B_IRAD} b_sel_t;
    typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_LOAD_RND, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {SH_0, SH_2, SH_22} shift_t;
    typedef enum logic [1:0] {DST_NONE, DST_CX, DST_CY, DST_CZ} dst_t;

    typedef struct packed {
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        acc_op_t    acc_op;
        shift_t     shift;
        dst_t       dst;
        logic       sum_ld;
        logic       sum_neg_y;
        logic       sum_neg_z;
        logic       wheel_wr;
        logic [1:0] wheel_idx;
        logic       skip_jmp;   // jump to FIN_STEP when no reference is to be used
        logic       fin;
    } ucode_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } seq_stat_t;

    typedef logic [3:0][VEL_W-1:0] wheel_vec_t;

    // wheel order: front left, back left, back right, front right
    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '0;
        case (step)
            5'd0:  begin uc.a_sel = A_VX; uc.b_sel = B_COS; uc.acc_op = ACC_LOAD;
                         uc.skip_jmp = 1'b1; end
            5'd1:  begin uc.a_sel = A_VY; uc.b_sel = B_SIN; uc.acc_op = ACC_SUB; end
            5'd2:  begin uc.a_sel = A_WZ; uc.b_sel = B_OFFY; uc.acc_op = ACC_ADD;
                         uc.shift = SH_2; uc.dst = DST_CX; end
            5'd3:  begin uc.a_sel = A_VX; uc.b_sel = B_SIN; uc.acc_op = ACC_LOAD; end
            5'd4:  begin uc.a_sel = A_VY; uc.b_sel = B_COS; uc.acc_op = ACC_ADD; end
            5'd5:  begin uc.a_sel = A_WZ; uc.b_sel = B_OFFX; uc.acc_op = ACC_SUB;
                         uc.shift = SH_2; uc.dst = DST_CY; end
            5'd6:  begin uc.a_sel = A_WZ; uc.b_sel = B_CSUM; uc.acc_op = ACC_LOAD;
                         uc.shift = SH_2; uc.dst = DST_CZ; end
            5'd7:  begin uc.sum_ld = 1'b1; uc.sum_neg_y = 1'b1; uc.sum_neg_z = 1'b1; end
            5'd8, 5'd11, 5'd14, 5'd17:
                   begin uc.a_sel = A_SHI; uc.b_sel = B_IRAD; uc.acc_op = ACC_LOAD_RND;
                         uc.shift = SH_22; end
            5'd9, 5'd12, 5'd15, 5'd18:
                   begin uc.a_sel = A_SLO; uc.b_sel = B_IRAD; uc.acc_op = ACC_ADD; end
            5'd10: begin uc.wheel_wr = 1'b1; uc.wheel_idx = 2'd0;
                         uc.sum_ld = 1'b1; uc.sum_neg_z = 1'b1; end
            5'd13: begin uc.wheel_wr = 1'b1; uc.wheel_idx = 2'd1;
                         uc.sum_ld = 1'b1; uc.sum_neg_y = 1'b1; end
            5'd16: begin uc.wheel_wr = 1'b1; uc.wheel_idx = 2'd2; uc.sum_ld = 1'b1; end
            5'd19: begin uc.wheel_wr = 1'b1; uc.wheel_idx = 2'd3; end
            5'd20: begin uc.fin = 1'b1; end
            default: uc = '0;
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mwcg_sequencer.sv]
`default_nettype none

module mwcg_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             skip,
    input  wire logic             out_free,
    output mwcg_pkg::ucode_t      ctl,
    output mwcg_pkg::seq_stat_t   stat
);
    import mwcg_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        ctl         = busy_reg ? ucode(step_reg) : '0;
        stat.busy   = busy_reg;
        stat.finish = busy_reg && ctl.fin && out_free;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (ctl.fin)
        begin
            // hold on the last step until the output register is free
            if (out_free)
                busy_next = 1'b0;
        end
        else if (ctl.skip_jmp && skip)
            step_next = FIN_STEP;
        else
            step_next = step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mwcg_datapath.sv]
`default_nettype none

module mwcg_datapath (
    input  wire logic                          clk,
    input  wire mwcg_pkg::ucode_t              ctl,
    input  wire mwcg_pkg::cfg_t                cfg,
    input  wire logic signed [mwcg_pkg::VEL_W-1:0] vx,
    input  wire logic signed [mwcg_pkg::VEL_W-1:0] vy,
    input  wire logic signed [mwcg_pkg::VEL_W-1:0] wz,
    output mwcg_pkg::wheel_vec_t               wheels
);
    import mwcg_pkg::*;

    localparam logic signed [ACC_W-1:0]     RND_CONST = ACC_W'(1) << (CUT - 1);
    localparam int                          HI_W      = ACC_W - CUT;
    localparam logic signed [HI_W-1:0]      W_MAX     = HI_W'((1 << (VEL_W - 1)) - 1);
    localparam logic signed [HI_W-1:0]      W_MIN     = -HI_W'(1 << (VEL_W - 1));

    logic signed [VEL_W-1:0]  a_op;
    logic signed [OPB_W-1:0]  b_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext, prod_sh;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  cx_reg, cy_reg, cz_reg, s_reg, s_next;
    logic signed [HI_W-1:0]   acc_hi;
    logic        [VEL_W-1:0]  sat_val;
    wheel_vec_t               wheel_reg;

    always_comb
    begin
        case (ctl.a_sel)
            A_VX:    a_op = vx;
            A_VY:    a_op = vy;
            A_WZ:    a_op = wz;
            // upper part of the sum is signed, lower part unsigned
            A_SHI:   a_op = VEL_W'($signed(s_reg[SUM_W-1:CUT]));
            A_SLO:   a_op = {{(VEL_W - CUT){1'b0}}, s_reg[CUT-1:0]};
            default: a_op = '0;
        endcase

        case (ctl.b_sel)
            B_COS:   b_op = OPB_W'(cfg.cos_offset_angle);
            B_SIN:   b_op = OPB_W'(cfg.sin_offset_angle);
            B_OFFX:  b_op = OPB_W'(cfg.offset_x);
            B_OFFY:  b_op = OPB_W'(cfg.offset_y);
            B_CSUM:  b_op = {{(OPB_W - CSUM_W){1'b0}}, cfg.center_sum};
            B_IRAD:  b_op = {{(OPB_W - CFG_W){1'b0}}, cfg.inv_radius};
            default: b_op = '0;
        endcase
    end

    assign prod     = a_op * b_op;
    assign prod_ext = ACC_W'(prod);

    always_comb
    begin
        case (ctl.shift)
            SH_2:    prod_sh = prod_ext <<< 2;
            SH_22:   prod_sh = prod_ext <<< CUT;
            default: prod_sh = prod_ext;
        endcase

        case (ctl.acc_op)
            ACC_LOAD:     acc_next = prod_sh;
            ACC_LOAD_RND: acc_next = prod_sh + RND_CONST;
            ACC_ADD:      acc_next = acc_reg + prod_sh;
            ACC_SUB:      acc_next = acc_reg - prod_sh;
            default:      acc_next = acc_reg;
        endcase
    end

    // wheel sum: cx +/- cy +/- cz, bounded well inside SUM_W
    always_comb
    begin
        s_next = cx_reg + (ctl.sum_neg_y ? -cy_reg : cy_reg)
                        + (ctl.sum_neg_z ? -cz_reg : cz_reg);
    end

    // round already folded in, so only floor and clamp here
    always_comb
    begin
        acc_hi = acc_reg[ACC_W-1:CUT];
        if (acc_hi > W_MAX)
            sat_val = W_MAX[VEL_W-1:0];
        else if (acc_hi < W_MIN)
            sat_val = W_MIN[VEL_W-1:0];
        else
            sat_val = acc_hi[VEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        case (ctl.dst)
            DST_CX:  cx_reg <= acc_next[SUM_W-1:0];
            DST_CY:  cy_reg <= acc_next[SUM_W-1:0];
            DST_CZ:  cz_reg <= acc_next[SUM_W-1:0];
            default: ;
        endcase
        if (ctl.sum_ld)
            s_reg <= s_next;
        if (ctl.wheel_wr)
            wheel_reg[ctl.wheel_idx] <= sat_val;
    end

    assign wheels = wheel_reg;

endmodule

`default_nettype wire

[rtl/core/mecanum_wheel_command_generator.sv]
`default_nettype none

// Four-wheel mecanum command generator.
// Input channel (in_valid/in_ready): action 0 carries a velocity reference
// (vel_x, vel_y, yaw_rate, ref_age); action 1 is a control tick.
// A reference transaction gives no result; it is kept
// if the reference limit register is zero or ref_age is within it.
// Each tick gives exactly one result on the output channel
// (out_valid/out_ready): four saturated wheel speeds and drive_written.
// A tick with a fresh reference runs the full 21-step microprogram on one
// shared 24x17 multiplier-accumulator. A tick without a usable reference
// jumps straight to the last step. in_ready is low while the program
// runs.
// The result sits in an output register, so the next transaction is
// taken while it waits; if the receiver stalls, a further tick waits on
// its last step until the register is free.
// Configuration (cfg_wr_en, cfg_index, cfg_wdata) is to be written only
// while idle; the block does not enforce it. Reset loads the default
// registers and drops any held reference; no result is pending after reset.
module mecanum_wheel_command_generator (
    input  wire  logic                                   clk,
    input  wire  logic                                   rst_n,
    input  wire  logic                                   cfg_wr_en,
    input  wire  logic [mwcg_pkg::IDX_W-1:0]             cfg_index,
    input  wire  logic [mwcg_pkg::CFG_W-1:0]             cfg_wdata,
    input  wire  logic                                   in_valid,
    output logic                                         in_ready,
    input  wire  logic                                   action,
    input  wire  logic signed [mwcg_pkg::VEL_W-1:0]      vel_x,
    input  wire  logic signed [mwcg_pkg::VEL_W-1:0]      vel_y,
    input  wire  logic signed [mwcg_pkg::VEL_W-1:0]      yaw_rate,
    input  wire  logic [mwcg_pkg::AGE_W-1:0]             ref_age,
    output logic                                         out_valid,
    input  wire  logic                                   out_ready,
    output logic signed [mwcg_pkg::VEL_W-1:0]            wheel_front_left,
    output logic signed [mwcg_pkg::VEL_W-1:0]            wheel_back_left,
    output logic signed [mwcg_pkg::VEL_W-1:0]            wheel_back_right,
    output logic signed [mwcg_pkg::VEL_W-1:0]            wheel_front_right,
    output logic                                         drive_written
);
    import mwcg_pkg::*;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    cfg_t                    cfg_reg;

    logic                    held_valid_reg;
    logic signed [VEL_W-1:0] held_vx_reg, held_vy_reg, held_wz_reg;
    logic [AGE_W-1:0]        held_age_reg;
    logic [AGE_W-1:0]        ticks_reg;

    logic                    use_ref_reg;   // tick drives the held reference
    logic                    dw_reg;        // drive_written of the tick in flight

    logic                    out_valid_reg;
    logic                    dw_out_reg;
    wheel_vec_t              wheel_out_reg;

    logic                    in_acc, ref_acc, tick_acc;
    logic                    ref_ok, held_fresh, out_free;
    ucode_t                  ctl;
    seq_stat_t               stat;
    wheel_vec_t              wheels;

    assign in_ready  = !stat.busy;
    assign in_acc    = in_valid && in_ready;
    assign ref_acc   = in_acc && !action;
    assign tick_acc  = in_acc && action;
    assign out_free  = !out_valid_reg || out_ready;

    assign ref_ok     = (cfg_reg.ref_limit == '0) ||
                        (ref_age <= cfg_reg.ref_limit);
    assign held_fresh = (cfg_reg.ref_limit == '0) ||
                        (held_age_reg <= cfg_reg.ref_limit);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_limit         <= '0;
            cfg_reg.cmd_limit         <= '0;
            cfg_reg.cos_offset_angle  <= CFG_W'(16'sh4000);
            cfg_reg.sin_offset_angle  <= '0;
            cfg_reg.offset_x          <= '0;
            cfg_reg.offset_y          <= '0;
            cfg_reg.center_sum        <= CSUM_W'(4096);
            cfg_reg.inv_radius        <= CFG_W'(2560);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_REF_TIMEOUT: cfg_reg.ref_limit         <= cfg_wdata;
                REG_CMD_TIMEOUT: cfg_reg.cmd_limit         <= cfg_wdata;
                REG_COS_OFFSET:  cfg_reg.cos_offset_angle  <= cfg_wdata;
                REG_SIN_OFFSET:  cfg_reg.sin_offset_angle  <= cfg_wdata;
                REG_OFFSET_X:    cfg_reg.offset_x          <= cfg_wdata;
                REG_OFFSET_Y:    cfg_reg.offset_y          <= cfg_wdata;
                REG_CENTER_SUM:  cfg_reg.center_sum        <= cfg_wdata[CSUM_W-1:0];
                REG_INV_RADIUS:  cfg_reg.inv_radius        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // held reference, ageing and the per-tick decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_vx_reg    <= '0;
            held_vy_reg    <= '0;
            held_wz_reg    <= '0;
            held_age_reg   <= '0;
            ticks_reg      <= '0;
            use_ref_reg    <= 1'b0;
            dw_reg         <= 1'b0;
        end
        else if (ref_acc)
        begin
            if (ref_ok)
            begin
                held_valid_reg <= 1'b1;
                held_vx_reg    <= vel_x;
                held_vy_reg    <= vel_y;
                held_wz_reg    <= yaw_rate;
                held_age_reg   <= ref_age;
                ticks_reg      <= '0;
            end
        end
        else if (tick_acc)
        begin
            // comparisons use the counts from before this tick's increment
            use_ref_reg <= held_valid_reg && held_fresh;
            dw_reg      <= held_valid_reg || (cfg_reg.cmd_limit < ticks_reg);
            // consume-once with a zero limit, drop when stale
            if (held_valid_reg && ((cfg_reg.ref_limit == '0) || !held_fresh))
                held_valid_reg <= 1'b0;
            if (held_age_reg != AGE_MAX)
                held_age_reg <= held_age_reg + AGE_W'(1);
            if (ticks_reg != AGE_MAX)
                ticks_reg <= ticks_reg + AGE_W'(1);
        end
    end

    mwcg_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_acc),
        .skip     (!use_ref_reg),
        .out_free (out_free),
        .ctl      (ctl),
        .stat     (stat)
    );

    mwcg_datapath u_dp (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .vx     (held_vx_reg),
        .vy     (held_vy_reg),
        .wz     (held_wz_reg),
        .wheels (wheels)
    );

    // output register; wheels read zero unless the reference was driven
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stat.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.finish)
        begin
            wheel_out_reg <= use_ref_reg ? wheels : '0;
            dw_out_reg    <= dw_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign wheel_front_left  = wheel_out_reg[0];
    assign wheel_back_left   = wheel_out_reg[1];
    assign wheel_back_right  = wheel_out_reg[2];
    assign wheel_front_right = wheel_out_reg[3];
    assign drive_written     = dw_out_reg;

endmodule

`default_nettype wire
